[src/mono_page_framebuffer_draw_assert.svh]
// Assertion macros for the framebuffer draw block
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_ASSERT_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define MPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define MPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/mpf_pkg.sv]
// Package: types and constants of the page framebuffer block
package mpf_pkg;
  localparam int ScreenWidth  = 128;
  localparam int ScreenHeight = 64;
  localparam int Pages        = (ScreenHeight + 7) / 8;
  localparam int StoreBytes   = ScreenWidth * Pages;
  localparam int AddrW        = $clog2(StoreBytes);

  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0, OP_HLINE = 3'd1, OP_VLINE = 3'd2, OP_RECT = 3'd3,
    OP_GSTART = 3'd4, OP_GBYTE = 3'd5, OP_FILL = 3'd6, OP_READ = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_AREA_RD, ST_AREA_WR, ST_GLY_RD, ST_GLY_WR,
    ST_FILL, ST_READ, ST_READ2, ST_OUT
  } state_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] x_shift;
    logic [7:0] y_shift;
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] color;
    logic [7:0] data_byte;
    logic [9:0] byte_index;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       glyph_done;
    logic       status;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;       // capture request
    logic area_init;   // start area walk
    logic area_next;   // step area walk
    logic gly_start;   // glyph start
    logic gly_init;    // begin glyph byte
    logic gly_next;    // consume one glyph bit
    logic sweep_init;  // start store sweep
    logic sweep_next;  // step sweep
    logic mem_wr;      // write modified byte
    logic wr_sweep;    // write sweep pattern
    logic rsp_load;    // capture response
    logic read_op;     // store address from byte index
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       area_last;
    logic       cur_vis;   // current area pixel on screen
    logic       gly_active;
    logic       gly_end;   // glyph byte finished after this bit
    logic       gly_draw;  // current bit draws an on-screen pixel
    logic       sweep_last;
    logic       idx_ok;
    logic       size_zero;
  } sts_t;
endpackage

[src/mpf_if.sv]
// Valid/ready channel interface
interface mpf_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/mpf_ram.sv]
// Generic single-port RAM with registered read
module mpf_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

[src/mpf_datapath.sv]
// Datapath: request registers, walkers, glyph state and store
module mpf_datapath import mpf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  ctl_t ctl_i,
  output sts_t sts_o,
  output rsp_t rsp_o
);
  req_t req_q;
  logic [7:0] cx_q, cy_q, aw_q, ah_q; // area walk
  logic [7:0] gcol_q, grow_q, gcols_q, grows_q, gbx_q, gby_q;
  logic       gink_q, gact_q;
  logic [2:0] gbit_q;
  logic [AddrW-1:0] sw_q;
  logic [7:0] rdata;
  rsp_t rsp_q;

  // Request capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) req_q <= '0;
    else if (ctl_i.latch) req_q <= req_i;
  end

  logic ink;
  assign ink = (req_q.color != 8'd0);

  // Current pixel: area walk or glyph position
  logic [7:0] px, py, gx, gy;
  assign gx = gbx_q + gcol_q;
  assign gy = gby_q + grow_q;
  logic gly_mode;
  assign gly_mode = (req_q.operation == OP_GBYTE);
  assign px = gly_mode ? gx : cx_q;
  assign py = gly_mode ? gy : cy_q;
  logic vis;
  assign vis = ({1'b0, px} < 9'(ScreenWidth)) && ({1'b0, py} < 9'(ScreenHeight));
  logic [AddrW-1:0] pix_addr;
  assign pix_addr = AddrW'(px) + AddrW'(32'(py >> 3) * ScreenWidth);
  logic pix_ink;
  assign pix_ink = gly_mode ? gink_q : ink;
  logic [7:0] mask;
  assign mask = 8'd1 << py[2:0];

  // Area walk: column within row, then next row
  logic [7:0] aj_q, ai_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.area_init) begin
      cx_q <= req_q.x_pos; cy_q <= req_q.y_pos; aj_q <= '0; ai_q <= '0;
      case (req_q.operation)
        OP_PIXEL: begin aw_q <= 8'd1; ah_q <= 8'd1; end
        OP_HLINE: begin aw_q <= req_q.width; ah_q <= 8'd1; end
        OP_VLINE: begin aw_q <= 8'd1; ah_q <= req_q.width; end
        default:  begin aw_q <= req_q.width; ah_q <= req_q.height; end
      endcase
    end else if (ctl_i.area_next) begin
      if (aj_q + 8'd1 == aw_q) begin
        aj_q <= '0; cx_q <= req_q.x_pos; ai_q <= ai_q + 8'd1; cy_q <= cy_q + 8'd1;
      end else begin
        aj_q <= aj_q + 8'd1; cx_q <= cx_q + 8'd1;
      end
    end
  end
  assign sts_o.area_last = (aj_q + 8'd1 == aw_q) && (ai_q + 8'd1 == ah_q);
  assign sts_o.size_zero =
    ((req_q.operation == OP_HLINE || req_q.operation == OP_VLINE ||
      req_q.operation == OP_RECT) && req_q.width == 8'd0) ||
    (req_q.operation == OP_RECT && req_q.height == 8'd0);

  // Glyph state
  logic [7:0] ncol, nrow;
  logic wrap, fin;
  assign ncol = gcol_q + 8'd1;
  assign wrap = (ncol >= gcols_q);
  assign nrow = grow_q + 8'd1;
  assign fin  = wrap && (nrow >= grows_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcol_q <= '0; grow_q <= '0; gcols_q <= '0; grows_q <= '0;
      gbx_q <= '0; gby_q <= '0; gink_q <= 1'b0; gact_q <= 1'b0;
      gbit_q <= '0;
    end else if (ctl_i.gly_start) begin
      gbx_q <= req_q.x_pos + req_q.x_shift;
      gby_q <= req_q.y_pos + req_q.y_shift;
      gcols_q <= req_q.width; grows_q <= req_q.height;
      gink_q <= ink; gcol_q <= '0; grow_q <= '0;
      gact_q <= (req_q.width != 8'd0) && (req_q.height != 8'd0);
    end else if (ctl_i.gly_init) begin
      gbit_q <= 3'd7;
    end else if (ctl_i.gly_next) begin
      gbit_q <= gbit_q - 3'd1;
      if (wrap) begin
        gcol_q <= '0; grow_q <= nrow;
        if (fin) gact_q <= 1'b0;
      end else gcol_q <= ncol;
    end
  end
  assign sts_o.gly_active = gact_q;
  assign sts_o.gly_end = fin || (gbit_q == 3'd0);
  assign sts_o.gly_draw = req_q.data_byte[gbit_q] && vis;
  assign sts_o.cur_vis = vis;

  // Sweep counter for clear and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sw_q <= '0;
    else if (ctl_i.sweep_init) sw_q <= '0;
    else if (ctl_i.sweep_next) sw_q <= sw_q + AddrW'(1);
  end
  assign sts_o.sweep_last = (32'(sw_q) == StoreBytes - 1);

  assign sts_o.op = req_q.operation;
  assign sts_o.idx_ok = (32'(req_q.byte_index) < StoreBytes);

  // Store access
  logic we;
  logic [AddrW-1:0] addr;
  logic [7:0] wdata;
  always_comb begin
    we = ctl_i.mem_wr || ctl_i.wr_sweep;
    if (ctl_i.wr_sweep) begin
      addr = sw_q;
      wdata = (req_q.operation == OP_FILL) ? req_q.color : 8'd0;
    end else if (ctl_i.read_op) begin
      addr = AddrW'(req_q.byte_index);
      wdata = rdata;
    end else begin
      addr = pix_addr;
      wdata = pix_ink ? (rdata | mask) : (rdata & ~mask);
    end
  end
  mpf_ram #(.Width(8), .Depth(StoreBytes)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // Response register, loaded on the last cycle of a request
  always_ff @(posedge clk_i) begin
    if (ctl_i.rsp_load) begin
      rsp_q.read_data  <= (req_q.operation == OP_READ && sts_o.idx_ok) ? rdata : 8'd0;
      rsp_q.glyph_done <= gly_mode && ctl_i.gly_next && fin;
      rsp_q.status     <= gly_mode && !gact_q;
    end
  end
  assign rsp_o = rsp_q;
endmodule

[src/mpf_ctrl.sv]
// Controller state machine for the framebuffer draw block
module mpf_ctrl import mpf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  input  sts_t   sts_i,
  output ctl_t   ctl_o
);
  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (sts_i.sweep_last) state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: begin
        case (op_e'(sts_i.op))
          OP_PIXEL, OP_HLINE, OP_VLINE, OP_RECT:
            state_d = sts_i.size_zero ? ST_OUT : ST_AREA_RD;
          OP_GSTART: state_d = ST_OUT;
          OP_GBYTE: state_d = sts_i.gly_active ? ST_GLY_RD : ST_OUT;
          OP_FILL: state_d = ST_FILL;
          default: state_d = ST_READ2;
        endcase
      end
      ST_READ2: state_d = ST_OUT;
      ST_AREA_RD: state_d = sts_i.cur_vis ? ST_AREA_WR :
                            (sts_i.area_last ? ST_OUT : ST_AREA_RD);
      ST_AREA_WR: state_d = sts_i.area_last ? ST_OUT : ST_AREA_RD;
      ST_GLY_RD: state_d = sts_i.gly_draw ? ST_GLY_WR :
                           (sts_i.gly_end ? ST_OUT : ST_GLY_RD);
      ST_GLY_WR: state_d = sts_i.gly_end ? ST_OUT : ST_GLY_RD;
      ST_FILL: if (sts_i.sweep_last) state_d = ST_OUT;
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin ctl_o.wr_sweep = 1'b1; ctl_o.sweep_next = 1'b1; end
      ST_IDLE: begin in_ready_o = 1'b1; ctl_o.latch = in_valid_i; end
      ST_READ: begin
        ctl_o.area_init = 1'b1;
        ctl_o.gly_init = (op_e'(sts_i.op) == OP_GBYTE);
        ctl_o.gly_start = (op_e'(sts_i.op) == OP_GSTART);
        ctl_o.sweep_init = 1'b1;
        ctl_o.read_op = 1'b1;
      end
      ST_READ2: ctl_o.read_op = 1'b1;
      ST_AREA_RD: ctl_o.area_next = !sts_i.cur_vis;
      ST_AREA_WR: begin ctl_o.mem_wr = 1'b1; ctl_o.area_next = 1'b1; end
      ST_GLY_RD: ctl_o.gly_next = !sts_i.gly_draw;
      ST_GLY_WR: begin ctl_o.mem_wr = 1'b1; ctl_o.gly_next = 1'b1; end
      ST_FILL: begin ctl_o.wr_sweep = 1'b1; ctl_o.sweep_next = 1'b1; end
      ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
    // Response is captured on the step that leads into the output state
    ctl_o.rsp_load = (state_d == ST_OUT) && (state_q != ST_OUT);
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end
endmodule

[src/mono_page_framebuffer_draw.sv]
// Top level: 128x64 page framebuffer with drawing operations
// After reset the store is cleared by a pass over all 1024 bytes, during
// which no request is taken. A taken request is latched and then starts
// in a read state. Pixels, lines and rectangles walk their area, with a
// read and a write step on the single store port for each on-screen
// pixel and a read step alone for each off-screen one; glyph start,
// zero-size lines and rectangles and glyph bytes with no glyph active go
// straight to the result; a glyph byte takes a read step per bit up to
// the glyph end and a write step more per drawn pixel; fill sweeps the
// whole store; read uses two read states. The result register holds the
// response until taken; the next request is taken after that.
module mono_page_framebuffer_draw import mpf_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  mpf_if.sink   in_i,
  mpf_if.source out_o
);
  ctl_t ctl;
  sts_t sts;
  rsp_t rsp_dp;
  logic out_valid;

  mpf_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .out_valid_o(out_valid), .out_ready_i(out_o.ready), .sts_i(sts), .ctl_o(ctl)
  );

  mpf_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(in_i.data), .ctl_i(ctl),
    .sts_o(sts), .rsp_o(rsp_dp)
  );

  // Response channel
  assign out_o.valid = out_valid;
  assign out_o.data  = rsp_dp;
endmodule

[src/mpf_checker.sv]
// Port-level checker bound to the framebuffer draw top level
`include "mono_page_framebuffer_draw_assert.svh"
module mpf_checker import mpf_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  `MPF_ASSERT_IMP(a_no_in_while_out, clk_i, rst_ni, out_valid, !in_ready)
  `MPF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `MPF_ASSERT_IMP(a_one_flag, clk_i, rst_ni, out_valid,
    !(out_data.status && out_data.glyph_done))
endmodule

bind mono_page_framebuffer_draw mpf_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.data)
);

[sim/tb.sv]
// Testbench for the page framebuffer draw block: random and directed requests
`timescale 1ns / 100ps
module tb;
  import mpf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic failed = 1'b0;

  mpf_if #(.T(req_t)) req_ch ();
  mpf_if #(.T(rsp_t)) rsp_ch ();

  mono_page_framebuffer_draw u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_ch.sink), .out_o(rsp_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block state
  logic [7:0] shadow_fb [StoreBytes];
  logic [7:0] g_col, g_row, g_cols, g_rows, g_bx, g_by;
  logic       g_ink, g_act;
  rsp_t       rsp_queue [$];
  int         hold_off = 0;   // long receiver stall when nonzero

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < StoreBytes; i++) shadow_fb[i] = 8'h00;
    {g_col, g_row, g_cols, g_rows, g_bx, g_by, g_ink, g_act} = '0;
  end

  function automatic void plot_px(logic [7:0] x, logic [7:0] y, logic ink);
    int idx;
    if (x >= ScreenWidth || y >= ScreenHeight) return;
    idx = x + (y / 8) * ScreenWidth;
    shadow_fb[idx][y[2:0]] = ink;
  endfunction

  function automatic void paint_area(logic [7:0] x, logic [7:0] y, int w, int h,
                                     logic ink);
    for (int i = 0; i < h; i++)
      for (int j = 0; j < w; j++)
        plot_px(8'(x + j), 8'(y + i), ink);
  endfunction

  // Apply one request to the shadow and return its response
  function automatic rsp_t draw_result(req_t r);
    rsp_t o;
    logic ink;
    o = '0;
    ink = (r.color != 0);
    case (op_e'(r.operation))
      OP_PIXEL: plot_px(r.x_pos, r.y_pos, ink);
      OP_HLINE: paint_area(r.x_pos, r.y_pos, int'(r.width), 1, ink);
      OP_VLINE: paint_area(r.x_pos, r.y_pos, 1, int'(r.width), ink);
      OP_RECT:  paint_area(r.x_pos, r.y_pos, int'(r.width), int'(r.height), ink);
      OP_GSTART: begin
        g_bx = r.x_pos + r.x_shift;
        g_by = r.y_pos + r.y_shift;
        g_cols = r.width;
        g_rows = r.height;
        g_ink = ink;
        g_col = '0;
        g_row = '0;
        g_act = (r.width != 0) && (r.height != 0);
      end
      OP_GBYTE: begin
        if (!g_act) o.status = 1'b1;
        else begin
          for (int b = 7; b >= 0 && g_act; b--) begin
            if (r.data_byte[b]) plot_px(8'(g_bx + g_col), 8'(g_by + g_row), g_ink);
            g_col = g_col + 8'd1;
            if (g_col >= g_cols) begin
              g_col = '0;
              g_row = g_row + 8'd1;
              if (g_row >= g_rows) begin
                g_act = 1'b0;
                o.glyph_done = 1'b1;
              end
            end
          end
        end
      end
      OP_FILL: for (int i = 0; i < StoreBytes; i++) shadow_fb[i] = r.color;
      default: if (r.byte_index < StoreBytes) o.read_data = shadow_fb[r.byte_index];
    endcase
    return o;
  endfunction

  // Send one request with a random gap before it
  task automatic send_req(req_t r);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    rsp_queue.push_back(draw_result(r));
  endtask

  function automatic req_t rand_req();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic req_t mk(op_e op, logic [7:0] x, logic [7:0] y, logic [7:0] w,
                              logic [7:0] h, logic [7:0] c);
    req_t r;
    r = rand_req();
    r.operation = op;
    r.x_pos = x; r.y_pos = y; r.width = w; r.height = h; r.color = c;
    return r;
  endfunction

  // Stop offering and wait for every outstanding response
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (rsp_queue.size() != 0) @(posedge clk_i);
  endtask

  // Read back a handful of random bytes
  task automatic read_some(int n);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r = mk(OP_READ, 0, 0, 0, 0, 0);
      r.byte_index = $urandom_range(0, 9) == 0 ? 10'($urandom) : 10'($urandom_range(0, 1023));
      send_req(r);
    end
  endtask

  task automatic test_directed();
    req_t r;
    send_req(mk(OP_PIXEL, 0, 0, 0, 0, 8'hff));
    send_req(mk(OP_PIXEL, 127, 63, 0, 0, 1));
    send_req(mk(OP_PIXEL, 128, 64, 0, 0, 1));
    send_req(mk(OP_HLINE, 250, 5, 20, 0, 1));
    send_req(mk(OP_VLINE, 3, 60, 255, 0, 1));
    send_req(mk(OP_RECT, 10, 10, 0, 5, 1));
    send_req(mk(OP_RECT, 10, 10, 6, 0, 1));
    send_req(mk(OP_RECT, 8, 6, 9, 11, 0));
    send_req(mk(OP_GBYTE, 0, 0, 0, 0, 0));
    r = mk(OP_GSTART, 5, 5, 3, 3, 1);
    r.x_shift = 8'h80; r.y_shift = 8'h7f;
    send_req(r);
    r = mk(OP_GSTART, 120, 60, 3, 3, 1);
    r.x_shift = 8'hfe; r.y_shift = 8'h02;
    send_req(r);
    for (int i = 0; i < 2; i++) begin
      r = mk(OP_GBYTE, 0, 0, 0, 0, 0); r.data_byte = 8'hff; send_req(r);
    end
    send_req(mk(OP_GSTART, 1, 1, 0, 4, 1));
    send_req(mk(OP_GBYTE, 0, 0, 0, 0, 0));
    r = mk(OP_READ, 0, 0, 0, 0, 0); r.byte_index = 10'h3ff; send_req(r);
    read_some(4);
    send_req(mk(OP_FILL, 0, 0, 0, 0, 8'ha5));
    read_some(2);
    send_req(mk(OP_FILL, 0, 0, 0, 0, 8'h00));
    wait_drained();
  endtask

  // Glyph sequences with random content, mixed with noise
  task automatic test_random(int n);
    req_t r;
    int cnt;
    int nb;
    cnt = 0;
    while (cnt < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          r = mk(OP_GSTART, 8'($urandom_range(0, 140)), 8'($urandom_range(0, 72)),
                 8'($urandom_range(1, 12)), 8'($urandom_range(1, 10)),
                 8'($urandom_range(0, 3)));
          r.x_shift = 8'($urandom); r.y_shift = 8'($urandom);
          if ($urandom_range(0, 1)) begin r.x_shift = 8'($urandom_range(0, 7));
            r.y_shift = 8'($urandom_range(0, 7)); end
          send_req(r);
          nb = (r.width * r.height + 7) / 8 + $urandom_range(0, 1);
          for (int i = 0; i < nb; i++) begin
            r = rand_req();
            r.operation = ($urandom_range(0, 9) == 0) ? OP_READ : OP_GBYTE;
            send_req(r);
          end
          cnt += nb + 1;
        end
        4: begin
          r = rand_req();
          if (r.operation == OP_FILL && $urandom_range(0, 3) != 0) r.operation = OP_READ;
          if (r.operation inside {OP_HLINE, OP_VLINE, OP_RECT}) begin
            r.width = $urandom_range(0, 3) == 0 ? r.width : 8'($urandom_range(0, 12));
            r.height = $urandom_range(0, 3) == 0 ? r.height : 8'($urandom_range(0, 12));
            if (r.width > 40 && r.height > 40) r.height = 2;
          end
          send_req(r); cnt++;
        end
        5, 6: begin
          r = mk(OP_RECT, 8'($urandom_range(0, 135)), 8'($urandom_range(0, 70)),
                 8'($urandom_range(0, 10)), 8'($urandom_range(0, 10)),
                 8'($urandom_range(0, 1)));
          r.operation = op_e'($urandom_range(0, 3));
          send_req(r); cnt++;
        end
        default: begin read_some(3); cnt += 3; end
      endcase
    end
    wait_drained();
  endtask

  // Receiver holds off while requests keep coming
  task automatic test_backpressure();
    hold_off = 60;
    read_some(6);
    wait_drained();
  endtask

  // Response checker with random stalls
  initial begin
    int stall;
    rsp_t exp_rsp;
    @(posedge rst_ni);
    forever begin
      if (hold_off != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      if (rsp_queue.size() == 0) begin
        $display("%0t: unexpected response %h", $time, rsp_ch.data);
        failed = 1'b1;
      end else begin
        exp_rsp = rsp_queue.pop_front();
        if (rsp_ch.data.read_data !== exp_rsp.read_data) begin
          $display("%0t: read_data exp %h got %h", $time, exp_rsp.read_data,
                   rsp_ch.data.read_data);
          failed = 1'b1;
        end
        if (rsp_ch.data.glyph_done !== exp_rsp.glyph_done) begin
          $display("%0t: glyph_done exp %b got %b", $time, exp_rsp.glyph_done,
                   rsp_ch.data.glyph_done);
          failed = 1'b1;
        end
        if (rsp_ch.data.status !== exp_rsp.status) begin
          $display("%0t: status exp %b got %b", $time, exp_rsp.status, rsp_ch.data.status);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(1000);
    repeat (50) @(posedge clk_i);
    if (failed || rsp_queue.size() != 0) $display("tb failed");
    else $display("tb passed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb failed");
    $finish;
  end
endmodule

[sim.f]
+incdir+src
src/mpf_pkg.sv
src/mpf_if.sv
src/mpf_ram.sv
src/mpf_datapath.sv
src/mpf_ctrl.sv
src/mono_page_framebuffer_draw.sv
src/mpf_checker.sv
sim/tb.sv
